/* rtl/core/rrts_pkg.sv */
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes of the round-robin task scheduler: event modes,
// outcome and task status codes, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int ID_W          = 16;
  localparam int QUANT_W       = 8;
  localparam int NUM_QREG      = 4;

  // event modes
  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_ADD       = 3'd1;
  localparam logic [2:0] MODE_REMOVE    = 3'd2;
  localparam logic [2:0] MODE_SET_STATE = 3'd3;
  localparam logic [2:0] MODE_NICE      = 3'd4;
  localparam logic [2:0] MODE_QUERY     = 3'd5;

  // outcome codes
  localparam logic [2:0] OC_DONE      = 3'd0;
  localparam logic [2:0] OC_NOT_FOUND = 3'd1;
  localparam logic [2:0] OC_REFUSED   = 3'd2;
  localparam logic [2:0] OC_FULL      = 3'd3;
  localparam logic [2:0] OC_NO_READY  = 3'd4;

  // task status codes
  localparam logic [1:0] TS_RUNNING = 2'd0;
  localparam logic [1:0] TS_READY   = 2'd1;
  localparam logic [1:0] TS_BLOCKED = 2'd2;
  localparam logic [1:0] TS_DEAD    = 2'd3;

  // quantum register indexes
  localparam logic [1:0] CFG_Q_FG_HIGH = 2'd0;
  localparam logic [1:0] CFG_Q_FG_LOW  = 2'd1;
  localparam logic [1:0] CFG_Q_BG_HIGH = 2'd2;
  localparam logic [1:0] CFG_Q_BG_LOW  = 2'd3;

  // reserved task identifiers
  localparam logic [ID_W-1:0] ID_IDLE   = 16'd0;
  localparam logic [ID_W-1:0] ID_SYSTEM = 16'd1;

  // quantum reset values
  localparam logic [QUANT_W-1:0] QFG_HIGH_RST = 8'd3;
  localparam logic [QUANT_W-1:0] QFG_LOW_RST  = 8'd1;
  localparam logic [QUANT_W-1:0] QBG_HIGH_RST = 8'd3;
  localparam logic [QUANT_W-1:0] QBG_LOW_RST  = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_SCAN,
    ST_HEAD,
    ST_WALK,
    ST_ADDW,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic latch;
    logic disp;
    logic scan;
    logic head;
    logic walk;
    logic addw;
    logic done;
  } rrts_cmd_t;

  typedef struct packed {
    logic imm;
    logic use_scan;
    logic use_head;
    logic scan_hit;
    logic add_empty;
    logic head_end;
    logic walk_end;
    logic walk_addw;
  } rrts_sts_t;

endpackage

`default_nettype wire

/* rtl/core/rrts_ram.sv */
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/rrts_ctrl.sv */
// ----------------------------------------------------------------------------
// rrts_ctrl
// Controller of the scheduler: sequences dispatch, free-slot scan, head read,
// ring walk, second write of an add and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ctrl
  import rrts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire rrts_sts_t sts,
  output rrts_cmd_t      cmd
);

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        if (sts.imm)           state_nxt = ST_DONE;
        else if (sts.use_scan) state_nxt = ST_SCAN;
        else if (sts.use_head) state_nxt = ST_HEAD;
        else                   state_nxt = ST_WALK;
      end
      ST_SCAN: begin
        if (sts.scan_hit) state_nxt = sts.add_empty ? ST_DONE : ST_WALK;
      end
      ST_HEAD: begin
        state_nxt = sts.head_end ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        if (sts.walk_end) state_nxt = sts.walk_addw ? ST_ADDW : ST_DONE;
      end
      ST_ADDW: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    cmd.latch = (state_r == ST_IDLE) && start;
    cmd.disp  = (state_r == ST_DISP);
    cmd.scan  = (state_r == ST_SCAN);
    cmd.head  = (state_r == ST_HEAD);
    cmd.walk  = (state_r == ST_WALK);
    cmd.addw  = (state_r == ST_ADDW);
    cmd.done  = (state_r == ST_DONE);
    busy      = (state_r != ST_IDLE);
  end

endmodule

`default_nettype wire

/* rtl/core/rrts_dp.sv */
// ----------------------------------------------------------------------------
// rrts_dp
// Datapath of the scheduler: event latch, quantum registers, task table RAM,
// free mask, current slot, ring walk registers and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_dp
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rrts_cmd_t          cmd,
  output rrts_sts_t               sts,
  input  wire logic [2:0]         in_mode,
  input  wire logic [ID_W-1:0]    in_task_id,
  input  wire logic [1:0]         in_priority_class,
  input  wire logic [1:0]         in_task_status,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [QUANT_W-1:0] cfg_data,
  output logic [ID_W-1:0]         out_running_id,
  output logic                    out_running_valid,
  output logic                    out_switched,
  output logic [2:0]              out_outcome,
  output logic                    out_alive
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  // slot word: {id, status, class, link}
  localparam int WW    = IW + 4 + ID_W;
  localparam int CL_LO = IW;
  localparam int ST_LO = IW + 2;
  localparam int ID_LO = IW + 4;

  // event latch
  logic [2:0]      mode_r;
  logic [ID_W-1:0] id_r;
  logic [1:0]      cls_r, st_r;

  // scheduler state
  logic [QUANT_W-1:0] qreg_r [NUM_QREG];
  logic [MAX_TASKS-1:0] free_r, free_nxt;
  logic [IW-1:0]      cur_r, cur_nxt;
  logic [ID_W-1:0]    cur_id_r, cur_id_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [QUANT_W-1:0] qleft_r, qleft_nxt;

  // walk registers
  logic [IW-1:0] walk_addr_r, walk_addr_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [IW-1:0] prev_addr_r, prev_addr_nxt;
  logic [WW-1:0] prev_word_r, prev_word_nxt;
  logic [IW-1:0] scan_r, scan_nxt;
  logic          demoted_r, demoted_nxt;
  logic          any_r, any_nxt;

  // result registers
  logic [2:0] outcome_r, outcome_nxt;
  logic       switched_r, switched_nxt;
  logic       alive_r, alive_nxt;

  // table RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, rd;

  logic [IW-1:0]   rd_link;
  logic [1:0]      rd_cls, rd_st, eff_st;
  logic [ID_W-1:0] rd_id;
  logic            last, hit;
  logic [WW-1:0]   new_word;

  rrts_ram #(.WIDTH(WW), .DEPTH(MAX_TASKS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  assign rd_link  = rd[IW-1:0];
  assign rd_cls   = rd[CL_LO +: 2];
  assign rd_st    = rd[ST_LO +: 2];
  assign rd_id    = rd[ID_LO +: ID_W];
  assign last     = (steps_r == CW'(1));
  assign hit      = (rd_id == id_r);
  // slot demoted this tick reads as ready even if the RAM shows it stale
  assign eff_st   = (demoted_r && (walk_addr_r == cur_r)) ? TS_READY : rd_st;
  assign new_word = {id_r, st_r, cls_r, cur_r};

  // latch event fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      id_r   <= in_task_id;
      cls_r  <= in_priority_class;
      st_r   <= in_task_status;
    end
  end

  // quantum registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qreg_r[CFG_Q_FG_HIGH] <= QFG_HIGH_RST;
      qreg_r[CFG_Q_FG_LOW]  <= QFG_LOW_RST;
      qreg_r[CFG_Q_BG_HIGH] <= QBG_HIGH_RST;
      qreg_r[CFG_Q_BG_LOW]  <= QBG_LOW_RST;
    end else if (cfg_we) begin
      qreg_r[cfg_index] <= cfg_data;
    end
  end

  // event sequencing
  always_comb begin
    free_nxt      = free_r;
    cur_nxt       = cur_r;
    cur_id_nxt    = cur_id_r;
    count_nxt     = count_r;
    qleft_nxt     = qleft_r;
    walk_addr_nxt = walk_addr_r;
    steps_nxt     = steps_r;
    prev_addr_nxt = prev_addr_r;
    prev_word_nxt = prev_word_r;
    scan_nxt      = scan_r;
    demoted_nxt   = demoted_r;
    any_nxt       = any_r;
    outcome_nxt   = outcome_r;
    switched_nxt  = switched_r;
    alive_nxt     = alive_r;
    ram_we        = 1'b0;
    ram_waddr     = walk_addr_r;
    ram_wdata     = rd;
    ram_raddr     = walk_addr_r;
    sts           = '0;

    // dispatch: settle trivial outcomes, start the scan, the head read or the walk
    if (cmd.disp) begin
      switched_nxt  = 1'b0;
      alive_nxt     = 1'b0;
      any_nxt       = 1'b0;
      demoted_nxt   = 1'b0;
      scan_nxt      = '0;
      outcome_nxt   = OC_DONE;
      ram_raddr     = cur_r;
      walk_addr_nxt = cur_r;
      steps_nxt     = count_r;
      unique case (mode_r)
        MODE_TICK: begin
          if (count_r == '0) begin
            sts.imm     = 1'b1;
            outcome_nxt = OC_NO_READY;
          end else begin
            sts.use_head = 1'b1;
          end
        end
        MODE_ADD: begin
          if (count_r == CW'(MAX_TASKS)) begin
            sts.imm     = 1'b1;
            outcome_nxt = OC_FULL;
          end else begin
            sts.use_scan = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (id_r == ID_IDLE || id_r == ID_SYSTEM) begin
            sts.imm     = 1'b1;
            outcome_nxt = OC_REFUSED;
          end else if (count_r == '0) begin
            sts.imm     = 1'b1;
            outcome_nxt = OC_NOT_FOUND;
          end else begin
            sts.use_head = 1'b1;
          end
        end
        MODE_SET_STATE: begin
          if (id_r == ID_SYSTEM && st_r == TS_DEAD) begin
            sts.imm     = 1'b1;
            outcome_nxt = OC_REFUSED;
          end else if (count_r == '0) begin
            sts.imm     = 1'b1;
            outcome_nxt = OC_NOT_FOUND;
          end
        end
        MODE_NICE, MODE_QUERY: begin
          if (count_r == '0) begin
            sts.imm     = 1'b1;
            outcome_nxt = OC_NOT_FOUND;
          end
        end
        default: sts.imm = 1'b1;
      endcase
    end

    // scan for the lowest free slot
    if (cmd.scan) begin
      if (free_r[scan_r]) begin
        sts.scan_hit         = 1'b1;
        free_nxt[scan_r]     = 1'b0;
        if (count_r == '0) begin
          sts.add_empty = 1'b1;
          ram_we        = 1'b1;
          ram_waddr     = scan_r;
          ram_wdata     = {id_r, st_r, cls_r, scan_r};
          cur_nxt       = scan_r;
          cur_id_nxt    = id_r;
          count_nxt     = count_r + CW'(1);
        end else begin
          ram_raddr     = cur_r;
          walk_addr_nxt = cur_r;
          steps_nxt     = count_r;
        end
      end else begin
        scan_nxt = scan_r + IW'(1);
      end
    end

    // head word of the current slot for tick and remove
    if (cmd.head) begin
      ram_raddr     = rd_link;
      walk_addr_nxt = rd_link;
      steps_nxt     = count_r;
      prev_addr_nxt = cur_r;
      prev_word_nxt = rd;
      if (mode_r == MODE_TICK) begin
        if (qleft_r != '0 && rd_st == TS_RUNNING) begin
          sts.head_end = 1'b1;
          qleft_nxt    = qleft_r - QUANT_W'(1);
        end else if (rd_st == TS_RUNNING) begin
          ram_we                 = 1'b1;
          ram_waddr              = cur_r;
          ram_wdata              = rd;
          ram_wdata[ST_LO +: 2]  = TS_READY;
          demoted_nxt            = 1'b1;
        end
      end
    end

    // one ring step per cycle
    if (cmd.walk) begin
      ram_raddr     = rd_link;
      walk_addr_nxt = rd_link;
      steps_nxt     = steps_r - CW'(1);
      prev_addr_nxt = walk_addr_r;
      prev_word_nxt = rd;
      unique case (mode_r)
        MODE_TICK: begin
          if (eff_st == TS_READY) begin
            sts.walk_end          = 1'b1;
            ram_we                = 1'b1;
            ram_wdata[ST_LO +: 2] = TS_RUNNING;
            cur_nxt               = walk_addr_r;
            cur_id_nxt            = rd_id;
            qleft_nxt             = qreg_r[rd_cls];
            switched_nxt          = 1'b1;
          end else if (last) begin
            sts.walk_end = 1'b1;
            outcome_nxt  = OC_NO_READY;
          end
        end
        MODE_ADD: begin
          if (rd_link == cur_r || last) begin
            sts.walk_end      = 1'b1;
            sts.walk_addw     = 1'b1;
            ram_we            = 1'b1;
            ram_wdata[IW-1:0] = scan_r;
          end
        end
        MODE_REMOVE: begin
          if (hit) begin
            sts.walk_end = 1'b1;
            if (walk_addr_r == cur_r) begin
              outcome_nxt = OC_REFUSED;
            end else begin
              ram_we                 = 1'b1;
              ram_waddr              = prev_addr_r;
              ram_wdata              = prev_word_r;
              ram_wdata[IW-1:0]      = rd_link;
              free_nxt[walk_addr_r]  = 1'b1;
              count_nxt              = count_r - CW'(1);
            end
          end else if (last) begin
            sts.walk_end = 1'b1;
            outcome_nxt  = OC_NOT_FOUND;
          end
        end
        MODE_SET_STATE: begin
          if (hit) begin
            sts.walk_end          = 1'b1;
            ram_we                = 1'b1;
            ram_wdata[ST_LO +: 2] = st_r;
          end else if (last) begin
            sts.walk_end = 1'b1;
            outcome_nxt  = OC_NOT_FOUND;
          end
        end
        MODE_NICE: begin
          if (hit) begin
            sts.walk_end = 1'b1;
            if (id_r == ID_SYSTEM) begin
              outcome_nxt = OC_REFUSED;
            end else begin
              ram_we               = 1'b1;
              ram_wdata[CL_LO]     = ~rd[CL_LO];
            end
          end else if (last) begin
            sts.walk_end = 1'b1;
            outcome_nxt  = OC_NOT_FOUND;
          end
        end
        MODE_QUERY: begin
          if (hit) begin
            any_nxt = 1'b1;
            if (rd_st != TS_DEAD) alive_nxt = 1'b1;
          end
          if (last) begin
            sts.walk_end = 1'b1;
            outcome_nxt  = (any_r || hit) ? OC_DONE : OC_NOT_FOUND;
          end
        end
        default: sts.walk_end = 1'b1;
      endcase
    end

    // second write of an add: the new slot, linked to the current one
    if (cmd.addw) begin
      ram_we    = 1'b1;
      ram_waddr = scan_r;
      ram_wdata = new_word;
      count_nxt = count_r + CW'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= '1;
      cur_r   <= '0;
      count_r <= '0;
      qleft_r <= QUANT_W'(1);
    end else begin
      free_r  <= free_nxt;
      cur_r   <= cur_nxt;
      count_r <= count_nxt;
      qleft_r <= qleft_nxt;
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    cur_id_r    <= cur_id_nxt;
    walk_addr_r <= walk_addr_nxt;
    steps_r     <= steps_nxt;
    prev_addr_r <= prev_addr_nxt;
    prev_word_r <= prev_word_nxt;
    scan_r      <= scan_nxt;
    demoted_r   <= demoted_nxt;
    any_r       <= any_nxt;
    outcome_r   <= outcome_nxt;
    switched_r  <= switched_nxt;
    alive_r     <= alive_nxt;
  end

  // result beat fields
  assign out_running_valid = (count_r != '0);
  assign out_running_id    = out_running_valid ? cur_id_r : '0;
  assign out_switched      = switched_r;
  assign out_outcome       = outcome_r;
  assign out_alive         = alive_r;

endmodule

`default_nettype wire

/* rtl/core/round_robin_task_scheduler.sv */
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Task table kept in ring order with per-class time quanta.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with in_mode, in_task_id, in_priority_class and
//   in_task_status; the event is taken at an edge where start is high and
//   busy is low. busy stays high from that edge through the result beat.
//   Each event gives one result beat: out_valid is high for one cycle with
//   out_running_id, out_running_valid, out_switched, out_outcome, out_alive.
//   The receiver cannot stall; the beat is gone after that cycle.
//   An event runs through dispatch, then as needed the free-slot scan, the
//   head read, the ring walk and the second write of an add, and ends in
//   the result beat. The next event can be taken once busy has fallen
//   after the beat.
//   Ring steps run one per cycle, set by the registered RAM read port.
//   Quantum registers are written through cfg_we/cfg_index/cfg_data while
//   idle. The user is bound to this; the block does not enforce it. Reset
//   empties the table, selects slot 0, sets the quantum left to one and
//   the quantum registers to 3, 1, 3, 1.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_mode,
  input  wire logic [ID_W-1:0]    in_task_id,
  input  wire logic [1:0]         in_priority_class,
  input  wire logic [1:0]         in_task_status,
  output logic                    out_valid,
  output logic [ID_W-1:0]         out_running_id,
  output logic                    out_running_valid,
  output logic                    out_switched,
  output logic [2:0]              out_outcome,
  output logic                    out_alive,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [QUANT_W-1:0] cfg_data
);

  rrts_cmd_t cmd;
  rrts_sts_t sts;

  rrts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  rrts_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_mode),
    .in_task_id        (in_task_id),
    .in_priority_class (in_priority_class),
    .in_task_status    (in_task_status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_running_id    (out_running_id),
    .out_running_valid (out_running_valid),
    .out_switched      (out_switched),
    .out_outcome       (out_outcome),
    .out_alive         (out_alive)
  );

  // result beat strobe
  assign out_valid = cmd.done;

endmodule

`default_nettype wire

/* tb/tb_round_robin_task_scheduler.sv */
// ----------------------------------------------------------------------------
// tb_round_robin_task_scheduler
// Self-checking bench for the round-robin task scheduler. Events are driven
// through the start/busy command port, and each accepted event is run
// through a behavioral copy of the task ring. Every result beat is compared
// field by field against the oldest predicted beat. Phases change the
// quantum registers and the sender's idle rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler;
  import rrts_pkg::*;

  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam int SLOTS = MAX_TASKS_DEF;

  typedef struct {
    logic [ID_W-1:0] running_id;
    logic            running_valid;
    logic            switched;
    logic [2:0]      outcome;
    logic            alive;
  } sched_beat_t;

  // Ring model of the task table plus the queue of predicted beats
  class sched_scoreboard;
    logic [ID_W-1:0]    tid [SLOTS];
    logic [1:0]         tstat [SLOTS];
    logic [1:0]         tcls [SLOTS];
    logic [3:0]         tlink [SLOTS];
    bit [SLOTS-1:0]     slot_used;
    logic [3:0]         cur;
    int                 count;
    logic [QUANT_W-1:0] qleft;
    logic [QUANT_W-1:0] qreg [NUM_QREG];
    sched_beat_t        pending [$];
    int                 errors;

    function void clear();
      slot_used = '0;
      cur = '0;
      count = 0;
      qleft = QUANT_W'(1);
      qreg[CFG_Q_FG_HIGH] = QFG_HIGH_RST;
      qreg[CFG_Q_FG_LOW] = QFG_LOW_RST;
      qreg[CFG_Q_BG_HIGH] = QBG_HIGH_RST;
      qreg[CFG_Q_BG_LOW] = QBG_LOW_RST;
      errors = 0;
    endfunction

    // Walk count ring steps from a slot; return the first slot holding id
    function int locate(logic [3:0] from, logic [ID_W-1:0] id, output logic [3:0] prev);
      logic [3:0] s;
      s = from;
      prev = cur;
      for (int i = 0; i < count; i++) begin
        if (tid[s] == id) return int'(s);
        prev = s;
        s = tlink[s];
      end
      return -1;
    endfunction

    function void note_event(logic [2:0] mode, logic [ID_W-1:0] id, logic [1:0] cls,
                             logic [1:0] st);
      sched_beat_t b;
      logic [3:0] s, p;
      int f;
      bit hit;
      b.switched = 0;
      b.outcome = OC_DONE;
      b.alive = 0;
      case (mode)
        MODE_TICK: begin
          if (count == 0) b.outcome = OC_NO_READY;
          else if (qleft > 0 && tstat[cur] == TS_RUNNING) qleft--;
          else begin
            if (tstat[cur] == TS_RUNNING) tstat[cur] = TS_READY;
            s = tlink[cur];
            hit = 0;
            for (int i = 0; i < count && !hit; i++) begin
              if (tstat[s] == TS_READY) hit = 1;
              else s = tlink[s];
            end
            if (!hit) b.outcome = OC_NO_READY;
            else begin
              tstat[s] = TS_RUNNING;
              cur = s;
              qleft = qreg[tcls[s]];
              b.switched = 1;
            end
          end
        end
        MODE_ADD: begin
          if (count >= SLOTS) b.outcome = OC_FULL;
          else begin
            s = '0;
            hit = 0;
            for (int i = 0; i < SLOTS && !hit; i++)
              if (!slot_used[i]) begin
                s = 4'(i);
                hit = 1;
              end
            slot_used[s] = 1;
            tid[s] = id;
            tstat[s] = st;
            tcls[s] = cls;
            if (count == 0) begin
              cur = s;
              tlink[s] = s;
            end else begin
              p = cur;
              for (int i = 0; i < count && tlink[p] != cur; i++) p = tlink[p];
              tlink[p] = s;
              tlink[s] = cur;
            end
            count++;
          end
        end
        MODE_REMOVE: begin
          if (id == ID_IDLE || id == ID_SYSTEM) b.outcome = OC_REFUSED;
          else begin
            f = locate(tlink[cur], id, p);
            if (f < 0) b.outcome = OC_NOT_FOUND;
            else if (f == int'(cur)) b.outcome = OC_REFUSED;
            else begin
              tlink[p] = tlink[f];
              slot_used[f] = 0;
              count--;
            end
          end
        end
        MODE_SET_STATE: begin
          if (id == ID_SYSTEM && st == TS_DEAD) b.outcome = OC_REFUSED;
          else begin
            f = locate(cur, id, p);
            if (f < 0) b.outcome = OC_NOT_FOUND;
            else tstat[f] = st;
          end
        end
        MODE_NICE: begin
          f = locate(cur, id, p);
          if (f < 0) b.outcome = OC_NOT_FOUND;
          else if (id == ID_SYSTEM) b.outcome = OC_REFUSED;
          else tcls[f] = tcls[f] ^ 2'd1;
        end
        MODE_QUERY: begin
          s = cur;
          hit = 0;
          for (int i = 0; i < count; i++) begin
            if (tid[s] == id) begin
              hit = 1;
              if (tstat[s] != TS_DEAD) b.alive = 1;
            end
            s = tlink[s];
          end
          if (!hit) b.outcome = OC_NOT_FOUND;
        end
        default: ;
      endcase
      b.running_id = (count != 0) ? tid[cur] : '0;
      b.running_valid = (count != 0);
      pending.push_back(b);
    endfunction

    function void check_result(sched_beat_t got);
      sched_beat_t exp_b;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, running_id %h", $realtime, got.running_id);
        errors++;
        return;
      end
      exp_b = pending.pop_front();
      if (got.running_id !== exp_b.running_id) begin
        $display("%0t: running_id exp %h got %h", $realtime, exp_b.running_id,
                 got.running_id);
        errors++;
      end
      if (got.running_valid !== exp_b.running_valid) begin
        $display("%0t: running_valid exp %b got %b", $realtime, exp_b.running_valid,
                 got.running_valid);
        errors++;
      end
      if (got.switched !== exp_b.switched) begin
        $display("%0t: switched exp %b got %b", $realtime, exp_b.switched, got.switched);
        errors++;
      end
      if (got.outcome !== exp_b.outcome) begin
        $display("%0t: outcome exp %0d got %0d", $realtime, exp_b.outcome, got.outcome);
        errors++;
      end
      if (got.alive !== exp_b.alive) begin
        $display("%0t: alive exp %b got %b", $realtime, exp_b.alive, got.alive);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_mode;
  logic [ID_W-1:0]    in_task_id;
  logic [1:0]         in_priority_class;
  logic [1:0]         in_task_status;
  logic               out_valid;
  logic [ID_W-1:0]    out_running_id;
  logic               out_running_valid;
  logic               out_switched;
  logic [2:0]         out_outcome;
  logic               out_alive;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [QUANT_W-1:0] cfg_data;

  sched_scoreboard sb;
  int idle_pct;

  round_robin_task_scheduler DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_task_id        (in_task_id),
    .in_priority_class (in_priority_class),
    .in_task_status    (in_task_status),
    .out_valid         (out_valid),
    .out_running_id    (out_running_id),
    .out_running_valid (out_running_valid),
    .out_switched      (out_switched),
    .out_outcome       (out_outcome),
    .out_alive         (out_alive),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // Capture every result beat at the edge that ends it
  always @(posedge clk) begin
    sched_beat_t b;
    if (rst_n && out_valid) begin
      b.running_id = out_running_id;
      b.running_valid = out_running_valid;
      b.switched = out_switched;
      b.outcome = out_outcome;
      b.alive = out_alive;
      sb.check_result(b);
    end
  end

  // Drive one event beat; start stays high after acceptance so back-to-back
  // beats never toggle it within one step
  task automatic send_event(logic [2:0] mode, logic [ID_W-1:0] id, logic [1:0] cls,
                            logic [1:0] st);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_mode <= mode;
    in_task_id <= id;
    in_priority_class <= cls;
    in_task_status <= st;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_event(mode, id, cls, st);
  endtask

  // Drop start and hold until every predicted beat has arrived
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_quanta(logic [7:0] fgh, logic [7:0] fgl, logic [7:0] bgh,
                              logic [7:0] bgl);
    logic [7:0] v [NUM_QREG];
    logic [1:0] idx [NUM_QREG];
    v = '{fgh, fgl, bgh, bgl};
    idx = '{CFG_Q_FG_HIGH, CFG_Q_FG_LOW, CFG_Q_BG_HIGH, CFG_Q_BG_LOW};
    for (int i = 0; i < NUM_QREG; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= v[i];
      @(posedge clk);
      sb.qreg[idx[i]] = v[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly a small id pool so lookups hit; sometimes any 16-bit value
  function automatic logic [ID_W-1:0] pick_id();
    logic [ID_W-1:0] pool [8];
    pool = '{ID_IDLE, ID_SYSTEM, 16'h0002, 16'h0003, 16'h8000, 16'hFFFF, 16'h5A5A,
             16'hA5A5};
    if ($urandom_range(9) == 0) return ID_W'($urandom_range(16'hFFFF));
    return pool[$urandom_range(7)];
  endfunction

  task automatic random_events(int n);
    int r;
    logic [2:0] mode;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 35) mode = MODE_TICK;
      else if (r < 50) mode = MODE_ADD;
      else if (r < 62) mode = MODE_REMOVE;
      else if (r < 77) mode = MODE_SET_STATE;
      else if (r < 85) mode = MODE_NICE;
      else if (r < 97) mode = MODE_QUERY;
      else mode = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
      send_event(mode, pick_id(), 2'($urandom_range(3)), 2'($urandom_range(3)));
    end
  endtask

  initial begin
    int pct [4];
    pct = '{0, 85, 34, 0};
    sb = new;
    sb.clear();
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_TICK;
    in_task_id = '0;
    in_priority_class = '0;
    in_task_status = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_Q_FG_HIGH;
    cfg_data = '0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, protected ids, full table, spare modes
    send_event(MODE_TICK, 16'h0002, 2'd0, TS_READY);
    send_event(MODE_QUERY, 16'h0002, 2'd0, TS_READY);
    send_event(MODE_REMOVE, 16'h0002, 2'd0, TS_READY);
    send_event(MODE_ADD, ID_IDLE, 2'd0, TS_READY);
    send_event(MODE_ADD, ID_SYSTEM, 2'd1, TS_RUNNING);
    send_event(MODE_ADD, 16'hFFFF, 2'd3, TS_BLOCKED);
    send_event(MODE_ADD, 16'h8000, 2'd2, TS_DEAD);
    for (int i = 0; i < 12; i++)
      send_event(MODE_ADD, ID_W'(16'h0010 + i), i[1:0], TS_READY);
    send_event(MODE_ADD, 16'h0002, 2'd3, TS_READY);
    send_event(MODE_REMOVE, ID_IDLE, 2'd0, TS_READY);
    send_event(MODE_REMOVE, ID_SYSTEM, 2'd0, TS_READY);
    send_event(MODE_REMOVE, ID_IDLE + 16'h0000, 2'd0, TS_READY);
    send_event(MODE_SET_STATE, ID_SYSTEM, 2'd0, TS_DEAD);
    send_event(MODE_NICE, ID_SYSTEM, 2'd0, TS_READY);
    send_event(MODE_NICE, 16'h1234, 2'd0, TS_READY);
    send_event(MODE_SPARE_A, 16'hFFFF, 2'd3, TS_DEAD);
    send_event(MODE_SPARE_B, 16'h0000, 2'd0, TS_RUNNING);
    for (int i = 0; i < 6; i++) send_event(MODE_TICK, 16'h0000, 2'd0, TS_READY);
    send_event(MODE_REMOVE, 16'hFFFF, 2'd0, TS_READY);
    drain();

    // Random phases, each with its own quanta and idle rate
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_quanta(8'd0, 8'd255, 8'd1, 8'd2);
        1: write_quanta(8'd255, 8'd0, 8'd255, 8'd0);
        2: write_quanta(8'($urandom_range(4)), 8'($urandom_range(4)),
                        8'($urandom_range(255)), 8'($urandom_range(4)));
        default: write_quanta(8'd3, 8'd1, 8'd3, 8'd1);
      endcase
      idle_pct = pct[ph];
      random_events(200);
      if (ph == 1) drain();
      random_events(205);
      drain();
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
